>>> rtl/core/apd_pkg.sv
package apd_pkg;

  // Header layout
  localparam int unsigned SeqWidth  = 10;
  localparam logic [9:0]  SeqMask   = 10'h3ff;
  localparam logic [3:0]  HeaderLen = 4'd8;

  // Result kinds
  localparam logic [1:0] KIND_VIBRATION = 2'd0;
  localparam logic [1:0] KIND_SAMPLE    = 2'd1;
  localparam logic [1:0] KIND_FRAME_END = 2'd2;

  // Audio format that is played
  localparam logic [2:0] FORMAT_PCM = 3'd1;

  // Output queue depth
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [15:0] sample_value;
    logic               vibrate_on;
    logic               frame_last;
  } out_item_t;

  // Up to two results caused by one byte; v1 is only set with v0
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t r0;
    out_item_t r1;
  } result_pair_t;

endpackage

>>> rtl/core/apd_parse.sv
module apd_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  apd_pkg::in_item_t     in_item,
  output logic                  pair_valid,
  input  logic                  pair_take,
  output apd_pkg::result_pair_t pair
);

  // Deframer state
  logic [3:0] byte_index, byte_index_next;
  logic [7:0] header_first, header_first_next;
  logic [9:0] received_seq, received_seq_next;
  logic [9:0] expected_seq, expected_seq_next;
  logic       expected_known, expected_known_next;
  logic       vibrating_now, vibrating_now_next;
  logic       packet_accepted, packet_accepted_next;
  logic [8:0] pending_low, pending_low_next;

  apd_pkg::result_pair_t pair_next;
  logic                  accept;

  logic [2:0] hdr_format;
  logic       hdr_mono;
  logic       hdr_vib;
  logic       hdr_type;
  logic       seq_ok;

  assign in_stall = pair_valid && !pair_take;
  assign accept   = in_valid && !in_stall;

  assign hdr_format = header_first[7:5];
  assign hdr_mono   = header_first[4];
  assign hdr_vib    = header_first[3];
  assign hdr_type   = header_first[2];
  assign seq_ok     = !(expected_known && (expected_seq != received_seq));

  // Per-byte state update and result generation
  always_comb begin
    byte_index_next      = byte_index;
    header_first_next    = header_first;
    received_seq_next    = received_seq;
    expected_seq_next    = expected_seq;
    expected_known_next  = expected_known;
    vibrating_now_next   = vibrating_now;
    packet_accepted_next = packet_accepted;
    pending_low_next     = pending_low;
    pair_next            = '0;

    if (byte_index < apd_pkg::HeaderLen) begin
      if (byte_index == 4'd0) begin
        header_first_next = in_item.data_byte;
      end else if (byte_index == 4'd1) begin
        received_seq_next = {header_first[1:0], in_item.data_byte};
      end
      byte_index_next = byte_index + 4'd1;

      // Last header byte: sequence check and accept decision
      if (byte_index == apd_pkg::HeaderLen - 4'd1) begin
        packet_accepted_next = 1'b0;
        if (!hdr_type) begin
          expected_seq_next   = (received_seq + 10'd1) & apd_pkg::SeqMask;
          expected_known_next = 1'b1;
          if (seq_ok && hdr_format == apd_pkg::FORMAT_PCM && !hdr_mono) begin
            packet_accepted_next = 1'b1;
            if (hdr_vib != vibrating_now) begin
              pair_next.v0            = 1'b1;
              pair_next.r0.result_kind = apd_pkg::KIND_VIBRATION;
              pair_next.r0.vibrate_on  = hdr_vib;
              vibrating_now_next      = hdr_vib;
            end
            // Empty payload: bare frame end after any vibration change
            if (in_item.last_byte) begin
              if (pair_next.v0) begin
                pair_next.v1             = 1'b1;
                pair_next.r1.result_kind = apd_pkg::KIND_FRAME_END;
                pair_next.r1.frame_last  = 1'b1;
              end else begin
                pair_next.v0             = 1'b1;
                pair_next.r0.result_kind = apd_pkg::KIND_FRAME_END;
                pair_next.r0.frame_last  = 1'b1;
              end
            end
          end
        end
      end
    end else if (packet_accepted) begin
      // Payload byte of an accepted packet
      if (pending_low[8]) begin
        pair_next.v0              = 1'b1;
        pair_next.r0.result_kind  = apd_pkg::KIND_SAMPLE;
        pair_next.r0.sample_value = {in_item.data_byte, pending_low[7:0]};
        pair_next.r0.frame_last   = in_item.last_byte;
        pending_low_next          = '0;
      end else if (in_item.last_byte) begin
        pair_next.v0             = 1'b1;
        pair_next.r0.result_kind = apd_pkg::KIND_FRAME_END;
        pair_next.r0.frame_last  = 1'b1;
      end else begin
        pending_low_next = {1'b1, in_item.data_byte};
      end
    end

    // End of packet
    if (in_item.last_byte) begin
      byte_index_next      = '0;
      pending_low_next     = '0;
      packet_accepted_next = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      header_first    <= '0;
      received_seq    <= '0;
      expected_seq    <= '0;
      expected_known  <= 1'b0;
      vibrating_now   <= 1'b0;
      packet_accepted <= 1'b0;
      pending_low     <= '0;
    end else if (accept) begin
      byte_index      <= byte_index_next;
      header_first    <= header_first_next;
      received_seq    <= received_seq_next;
      expected_seq    <= expected_seq_next;
      expected_known  <= expected_known_next;
      vibrating_now   <= vibrating_now_next;
      packet_accepted <= packet_accepted_next;
      pending_low     <= pending_low_next;
    end
  end

  // Result pair register
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (accept) begin
      pair_valid <= pair_next.v0;
    end else if (pair_take) begin
      pair_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pair <= pair_next;
    end
  end

endmodule

>>> rtl/core/apd_outq.sv
module apd_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pair_valid,
  output logic                  pair_take,
  input  apd_pkg::result_pair_t pair,
  output logic                  out_valid,
  input  logic                  out_stall,
  output apd_pkg::out_item_t    out_item
);

  localparam int unsigned PtrW = $clog2(apd_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(apd_pkg::QueueDepth + 1);

  apd_pkg::out_item_t entries [apd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic [PtrW-1:0] wr_ptr_1;
  logic            pop;
  logic [CntW-1:0] n_push;

  // Take a pair only when two slots are free
  assign pair_take = pair_valid && (count <= CntW'(apd_pkg::QueueDepth - 2));
  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_1  = wr_ptr + PtrW'(1);

  always_comb begin
    n_push = '0;
    if (pair_take) begin
      n_push = CntW'(pair.v0) + CntW'(pair.v1);
    end
    count_next = count + n_push - CntW'(pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[PtrW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (pair_take && pair.v0) begin
      entries[wr_ptr] <= pair.r0;
    end
    if (pair_take && pair.v1) begin
      entries[wr_ptr_1] <= pair.r1;
    end
  end

endmodule

>>> rtl/core/audio_packet_deframer_core.sv
// Audio packet deframer: one byte item accepted per cycle while in_stall is low.
// A result is loaded into the result pair register at the edge that accepts its
// byte, is written into the output queue when the queue takes the pair, and is
// then presented on out_item.
// A byte that causes two results writes both into the four-entry output queue at
// once; the queue absorbs them, so input rate is one byte per cycle unless stalled.
// Reset (rst, synchronous, active high) clears all deframer state and the queue.
module audio_packet_deframer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  apd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output apd_pkg::out_item_t out_item
);

  logic                  pair_valid;
  logic                  pair_take;
  apd_pkg::result_pair_t pair;

  apd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .pair_valid (pair_valid),
    .pair_take  (pair_take),
    .pair       (pair)
  );

  apd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_take  (pair_take),
    .pair       (pair),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 1000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  apd_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  apd_pkg::out_item_t out_item;

  audio_packet_deframer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be sent, and results the deframer must still produce
  apd_pkg::in_item_t  byte_stream[$];
  apd_pkg::out_item_t deframed_results[$];

  int unsigned total_bytes = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned samples_seen = 0;
  int unsigned vib_seen = 0;
  int unsigned bare_ends_seen = 0;
  int unsigned packets_played = 0;
  int unsigned packets_dropped = 0;

  // Predictor state
  logic [3:0] hdr_count = '0;
  logic [7:0] hdr_lead = '0;
  logic [9:0] rx_seq = '0;
  logic [9:0] next_seq = '0;
  logic       seq_locked = 1'b0;
  logic       vib_state = 1'b0;
  logic       pkt_live = 1'b0;
  logic [8:0] held_low = '0;   // bit 8: low byte held

  // Stimulus-side view of the sequence number
  logic [9:0] gen_seq = '0;
  logic       gen_locked = 1'b0;

  // Handshake pacing
  int send_gap = 0;
  int send_calm = 0;
  int recv_hold = 0;
  int recv_calm = 0;

  function automatic apd_pkg::out_item_t make_result(logic [1:0] kind, logic [15:0] smp,
                                                     logic vib, logic fin);
    apd_pkg::out_item_t r;
    r.result_kind  = kind;
    r.sample_value = smp;
    r.vibrate_on   = vib;
    r.frame_last   = fin;
    return r;
  endfunction

  // Mostly short delays, a few long ones
  function automatic int pick_delay();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Append one predicted result
  task automatic expect_result(input apd_pkg::out_item_t r);
    deframed_results.insert(deframed_results.size(), r);
  endtask

  // Advance the predictor by one accepted byte
  task automatic deframe_byte(input apd_pkg::in_item_t it);
    logic seq_ok;
    if (hdr_count < apd_pkg::HeaderLen) begin
      if (hdr_count == 4'd0) begin
        hdr_lead = it.data_byte;
      end else if (hdr_count == 4'd1) begin
        rx_seq = {hdr_lead[1:0], it.data_byte};
      end
      // header complete: sequence check and accept decision
      if (hdr_count == apd_pkg::HeaderLen - 4'd1) begin
        pkt_live = 1'b0;
        if (!hdr_lead[2]) begin
          seq_ok = !seq_locked || (next_seq == rx_seq);
          next_seq = (rx_seq + 10'd1) & apd_pkg::SeqMask;
          seq_locked = 1'b1;
          if (seq_ok && hdr_lead[7:5] == apd_pkg::FORMAT_PCM && !hdr_lead[4]) begin
            pkt_live = 1'b1;
            if (hdr_lead[3] != vib_state) begin
              expect_result(make_result(apd_pkg::KIND_VIBRATION, '0, hdr_lead[3], 1'b0));
              vib_state = hdr_lead[3];
            end
            if (it.last_byte) begin
              expect_result(make_result(apd_pkg::KIND_FRAME_END, '0, 1'b0, 1'b1));
            end
          end
        end
        if (pkt_live) packets_played++;
        else packets_dropped++;
      end
      hdr_count = hdr_count + 4'd1;
    end else if (pkt_live) begin
      // payload: little-endian sample pairs
      if (held_low[8]) begin
        expect_result(make_result(apd_pkg::KIND_SAMPLE, {it.data_byte, held_low[7:0]},
                                  1'b0, it.last_byte));
        held_low = '0;
      end else if (it.last_byte) begin
        expect_result(make_result(apd_pkg::KIND_FRAME_END, '0, 1'b0, 1'b1));
      end else begin
        held_low = {1'b1, it.data_byte};
      end
    end
    if (it.last_byte) begin
      hdr_count = '0;
      held_low = '0;
      pkt_live = 1'b0;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin);
    byte_stream.insert(byte_stream.size(), {b, fin});
  endtask

  // Eight header bytes; bytes 2..7 carry random filler
  task automatic add_header(input logic [2:0] fmt, input logic mono, input logic vib,
                            input logic typ, input logic [9:0] seq, input logic fin);
    push_byte({fmt, mono, vib, typ, seq[9:8]}, 1'b0);
    push_byte(seq[7:0], 1'b0);
    for (int i = 2; i < 8; i++) push_byte(8'($urandom_range(0, 255)), fin && i == 7);
    if (!typ) begin
      gen_seq = seq + 10'd1;
      gen_locked = 1'b1;
    end
  endtask

  // Driver: holds an item until it is taken, then waits out its gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_item);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          in_item <= byte_stream.pop_front();
          in_valid <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
          end else if ($urandom_range(0, 63) == 0) begin
            send_calm = $urandom_range(30, 120);
          end else begin
            send_gap = pick_delay();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    apd_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        case (out_item.result_kind)
          apd_pkg::KIND_SAMPLE:    samples_seen++;
          apd_pkg::KIND_VIBRATION: vib_seen++;
          default:                 bare_ends_seen++;
        endcase
        if (deframed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: kind %0d sample %0d vib %0d last %0d",
                     out_item.result_kind, $signed(out_item.sample_value),
                     out_item.vibrate_on, out_item.frame_last);
        end else begin
          want = deframed_results.pop_front();
          if (out_item.result_kind !== want.result_kind ||
              out_item.sample_value !== want.sample_value ||
              out_item.vibrate_on !== want.vibrate_on ||
              out_item.frame_last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at result %0d: kind %0d/%0d sample %0d/%0d ",
                        "vib %0d/%0d last %0d/%0d (exp/got)"},
                       results_seen, want.result_kind, out_item.result_kind,
                       $signed(want.sample_value), $signed(out_item.sample_value),
                       want.vibrate_on, out_item.vibrate_on,
                       want.frame_last, out_item.frame_last);
          end
        end
      end
      // backpressure
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(0, 63) == 0) recv_calm = $urandom_range(30, 120);
        else recv_hold = pick_delay();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, deframed_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned useful;
    int          roll;
    int          plen;
    int          slen;
    logic [2:0]  fmt;
    logic        mono;
    logic        vib;
    logic        typ;
    logic [9:0]  seq;

    // short packet, all-ones then all-zeros byte
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b1);
    // first packet adopted at top sequence value; vibration on, extreme samples,
    // odd trailing byte
    add_header(apd_pkg::FORMAT_PCM, 1'b0, 1'b1, 1'b0, 10'h3ff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'hff, 1'b1);
    // sequence wraps to zero; empty payload with a vibration change
    add_header(apd_pkg::FORMAT_PCM, 1'b0, 1'b0, 1'b0, 10'h000, 1'b1);
    // sequence mismatch
    add_header(apd_pkg::FORMAT_PCM, 1'b0, 1'b1, 1'b0, 10'h005, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);

    // random packets, mostly well formed
    useful = 0;
    while (useful < 1200) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        slen = $urandom_range(1, 7);
        for (int i = 0; i < slen; i++) push_byte(8'($urandom_range(0, 255)), i == slen - 1);
        useful += slen;
      end else begin
        fmt  = apd_pkg::FORMAT_PCM;
        mono = 1'b0;
        typ  = 1'b0;
        vib  = 1'($urandom_range(0, 1));
        seq  = gen_locked ? gen_seq : 10'($urandom_range(0, 1023));
        if (roll < 70) begin
        end else if (roll < 78) begin
          fmt  = 3'($urandom_range(0, 7));
          mono = 1'($urandom_range(0, 1));
          typ  = 1'b1;
          seq  = 10'($urandom_range(0, 1023));
        end else if (roll < 85) begin
          seq = gen_seq + 10'($urandom_range(1, 1023));
        end else if (roll < 92) begin
          fmt = 3'($urandom_range(2, 8));
        end else begin
          mono = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 80) plen = $urandom_range(0, 12);
        else if (roll < 95) plen = $urandom_range(13, 40);
        else plen = $urandom_range(41, 64);
        add_header(fmt, mono, vib, typ, seq, plen == 0);
        for (int i = 0; i < plen; i++) push_byte(8'($urandom_range(0, 255)), i == plen - 1);
        useful += 8 + plen;
      end
    end
    total_bytes = byte_stream.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (bytes_sent != total_bytes || deframed_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (deframed_results.size() != 0) begin
      $display("%0d predicted results never arrived", deframed_results.size());
      mismatches += deframed_results.size();
    end
    $display("Sent %0d bytes; %0d full headers: %0d packets played, %0d dropped.",
             bytes_sent, packets_played + packets_dropped, packets_played, packets_dropped);
    $display("Checked %0d results: %0d samples, %0d vibration changes, %0d bare frame ends.",
             results_seen, samples_seen, vib_seen, bare_ends_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
